// ----- src/plst_pkg.sv -----
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and constants for the positional list store: command codes,
// item structs and the default list capacity.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        count;
        logic                      empty_res;
    } out_item_t;

endpackage

// ----- src/plst_ram.sv -----
// ----------------------------------------------------------------------------
// plst_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/positional_list_store_top.sv -----
// Path to the result register: clear, failed commands and a tail remove go
// straight to ST_DONE; a read passes ST_RD_ISSUE, ST_RD_WAIT; a tail insert
// passes ST_WR_LAST; other inserts shift, then ST_DRAIN, ST_WR_LAST; other
// removes shift, then ST_DRAIN. A stalled output holds the result in ST_DONE.
// The next item is taken in the cycle after the result is registered. Shifts
// move one entry per cycle through the list RAM. Reset empties the list at once.
// ----------------------------------------------------------------------------
// positional_list_store_top
// Ordered list of signed 32-bit values held in a RAM. Insert and remove
// shift the tail of the list one entry per cycle by read and write back.
// ----------------------------------------------------------------------------
module positional_list_store_top #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  plst_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output plst_pkg::out_item_t out_item
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > plst_pkg::POS_W) ? CNT_W : plst_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DRAIN,
        ST_WR_LAST,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CW-1:0]               ptr_reg;
    logic [CW-1:0]               pos_reg;
    logic [plst_pkg::VALUE_W-1:0] value_reg;
    logic                        is_ins_reg;
    logic                        prev_valid_reg;
    logic [AW-1:0]               prev_addr_reg;
    logic                        res_ok_reg;
    logic [plst_pkg::VALUE_W-1:0] res_val_reg;
    logic                        out_valid_reg;
    plst_pkg::out_item_t         out_item_reg;

    logic                        accept;
    logic [CW-1:0]               cnt_ext;
    logic [CW-1:0]               in_pos;
    logic [CW-1:0]               ptr_up;
    logic [CW-1:0]               ptr_dn;
    logic                        shift_last;
    logic                        out_free;

    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [plst_pkg::VALUE_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [AW-1:0]               ram_rd_addr;
    logic [plst_pkg::VALUE_W-1:0] ram_rd_data;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign cnt_ext  = CW'(count_reg);
    assign in_pos   = CW'(in_item.position);
    assign ptr_up   = ptr_reg + CW'(1);
    assign ptr_dn   = ptr_reg - CW'(1);
    assign out_free = !out_valid_reg || !out_stall;

    // Insert walks down to the target position; remove walks up to the tail.
    assign shift_last = is_ins_reg ? (ptr_reg == pos_reg) : (ptr_reg == cnt_ext - CW'(1));

    always_comb
    begin
        ram_rd_en   = (state_reg == ST_SHIFT) || (state_reg == ST_RD_ISSUE);
        ram_rd_addr = ptr_reg[AW-1:0];
        ram_wr_en   = (((state_reg == ST_SHIFT) || (state_reg == ST_DRAIN)) && prev_valid_reg)
                      || (state_reg == ST_WR_LAST);
        if (state_reg == ST_WR_LAST)
        begin
            ram_wr_addr = pos_reg[AW-1:0];
            ram_wr_data = value_reg;
        end
        else
        begin
            ram_wr_addr = prev_addr_reg;
            ram_wr_data = ram_rd_data;
        end
    end

    plst_ram #(
        .WIDTH (plst_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            pos_reg        <= '0;
            value_reg      <= '0;
            is_ins_reg     <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_addr_reg  <= '0;
            res_ok_reg     <= 1'b0;
            res_val_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            // In ST_DONE the valid flag is handled by that state's arm.
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pos_reg     <= in_pos;
                        value_reg   <= in_item.value;
                        res_ok_reg  <= 1'b0;
                        res_val_reg <= '0;
                        state_reg   <= ST_DONE;
                        case (in_item.command)
                            plst_pkg::CMD_INSERT:
                            begin
                                if ((in_pos <= cnt_ext) && (cnt_ext < CW'(CAPACITY)))
                                begin
                                    res_ok_reg <= 1'b1;
                                    is_ins_reg <= 1'b1;
                                    ptr_reg    <= cnt_ext - CW'(1);
                                    if (in_pos == cnt_ext)
                                    begin
                                        state_reg <= ST_WR_LAST;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_SHIFT;
                                    end
                                end
                            end
                            plst_pkg::CMD_REMOVE:
                            begin
                                if (in_pos < cnt_ext)
                                begin
                                    res_ok_reg <= 1'b1;
                                    is_ins_reg <= 1'b0;
                                    ptr_reg    <= in_pos + CW'(1);
                                    if (in_pos + CW'(1) == cnt_ext)
                                    begin
                                        count_reg <= count_reg - CNT_W'(1);
                                    end
                                    else
                                    begin
                                        state_reg <= ST_SHIFT;
                                    end
                                end
                            end
                            plst_pkg::CMD_READ:
                            begin
                                if (in_pos < cnt_ext)
                                begin
                                    res_ok_reg <= 1'b1;
                                    ptr_reg    <= in_pos;
                                    state_reg  <= ST_RD_ISSUE;
                                end
                            end
                            default:
                            begin
                                res_ok_reg <= 1'b1;
                                count_reg  <= '0;
                            end
                        endcase
                    end
                end
                ST_SHIFT:
                begin
                    // Each entry read here is written one place over in the next cycle.
                    prev_valid_reg <= 1'b1;
                    prev_addr_reg  <= is_ins_reg ? ptr_up[AW-1:0] : ptr_dn[AW-1:0];
                    ptr_reg        <= is_ins_reg ? ptr_dn : ptr_up;
                    if (shift_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    prev_valid_reg <= 1'b0;
                    if (is_ins_reg)
                    begin
                        state_reg <= ST_WR_LAST;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= ST_DONE;
                    end
                end
                ST_WR_LAST:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_DONE;
                end
                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_WAIT;
                end
                ST_RD_WAIT:
                begin
                    res_val_reg <= ram_rd_data;
                    state_reg   <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_item_reg.ok         <= res_ok_reg;
                        out_item_reg.read_value <= res_val_reg;
                        out_item_reg.count      <= cnt_ext[plst_pkg::COUNT_W-1:0];
                        out_item_reg.empty_res  <= (count_reg == '0);
                        state_reg               <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- tb/sv/plst_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plst_checker
// Watches both channels of the positional list store. It keeps its own copy
// of the list, works out the result of every accepted command, and compares
// each accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module plst_checker #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  plst_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_stall,
    input  plst_pkg::out_item_t out_item,
    output int                  fail_count,
    output int                  waiting_results,
    output int                  list_size
);

    logic signed [plst_pkg::VALUE_W-1:0] list_values[$];
    plst_pkg::out_item_t                 pending_results[$];
    int                                  failures = 0;
    int                                  pending_count = 0;
    int                                  entry_count = 0;

    assign fail_count      = failures;
    assign waiting_results = pending_count;
    assign list_size       = entry_count;

    // Applies one command to the local list and returns the result it causes.
    function automatic plst_pkg::out_item_t apply_command(plst_pkg::in_item_t cmd);
        plst_pkg::out_item_t res;
        res = '0;
        case (cmd.command)
            plst_pkg::CMD_INSERT:
            begin
                if (cmd.position <= list_values.size() && list_values.size() < CAPACITY)
                begin
                    list_values.insert(cmd.position, cmd.value);
                    res.ok = 1'b1;
                end
            end
            plst_pkg::CMD_REMOVE:
            begin
                if (cmd.position < list_values.size())
                begin
                    list_values.delete(cmd.position);
                    res.ok = 1'b1;
                end
            end
            plst_pkg::CMD_READ:
            begin
                if (cmd.position < list_values.size())
                begin
                    res.read_value = list_values[cmd.position];
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                list_values.delete();
                res.ok = 1'b1;
            end
        endcase
        res.count     = plst_pkg::COUNT_W'(list_values.size());
        res.empty_res = (list_values.size() == 0);
        return res;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        plst_pkg::out_item_t want;
        if (rst_n)
        begin
            // Results are taken before commands, so that a result can never be
            // matched against a command accepted at the same edge.
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with no command waiting: %p", out_item);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("ok", want.ok, out_item.ok);
                    compare_field("read_value", want.read_value, out_item.read_value);
                    compare_field("count", want.count, out_item.count);
                    compare_field("empty_res", want.empty_res, out_item.empty_res);
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(apply_command(in_item));
            pending_count <= pending_results.size();
            entry_count   <= list_values.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the positional list store with a short directed list of commands
// and then with random traffic in fill, drain, mixed and noise phases, with
// random gaps on both channels. The checker beside the block gives the counts
// of failures and of waiting results that decide the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS   = 750;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int PAUSE_AT_ITEM  = 400;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 100;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} traffic_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    plst_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    plst_pkg::out_item_t out_item;

    int fail_count;
    int waiting_results;
    int list_size;
    int quiet_cycles = 0;
    int results_taken = 0;
    bit sender_bursting = 1'b0;
    bit receiver_bursting = 1'b0;

    always #2 clk = ~clk;

    positional_list_store_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    plst_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item),
        .fail_count      (fail_count),
        .waiting_results (waiting_results),
        .list_size       (list_size)
    );

    // Offers one item after a random gap, or none while bursting, and returns at the edge that takes it.
    task automatic send_item(logic [plst_pkg::CMD_W-1:0] command, int position,
                             logic signed [plst_pkg::VALUE_W-1:0] value);
        int gap;
        gap = sender_bursting ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= plst_pkg::in_item_t'{command: command,
                                         position: plst_pkg::POS_W'(position),
                                         value: value};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random(traffic_mode_t mode);
        int                          roll;
        int                          t_insert;
        int                          t_remove;
        int                          t_read;
        int                          position;
        logic [plst_pkg::CMD_W-1:0]  command;
        case (mode)
            MODE_FILL:
            begin
                t_insert = 85;
                t_remove = 92;
                t_read   = 99;
            end
            MODE_DRAIN:
            begin
                t_insert = 15;
                t_remove = 80;
                t_read   = 99;
            end
            MODE_MIXED:
            begin
                t_insert = 35;
                t_remove = 65;
                t_read   = 98;
            end
            default:
            begin
                t_insert = 25;
                t_remove = 50;
                t_read   = 75;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < t_insert)
            command = plst_pkg::CMD_INSERT;
        else if (roll < t_remove)
            command = plst_pkg::CMD_REMOVE;
        else if (roll < t_read)
            command = plst_pkg::CMD_READ;
        else
            command = plst_pkg::CMD_CLEAR;
        // Mostly positions that the current list allows; now and then anything.
        if (mode == MODE_NOISE || $urandom_range(0, 9) == 0)
            position = $urandom_range(0, 127);
        else if (command == plst_pkg::CMD_INSERT)
            position = $urandom_range(0, list_size);
        else
            position = (list_size > 0) ? $urandom_range(0, list_size - 1) : 0;
        send_item(command, position, $urandom);
    endtask

    initial
    begin
        int            sent;
        int            seg_len;
        int            roll;
        traffic_mode_t mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: clear, out of range accesses, insert past the end.
        send_item(plst_pkg::CMD_CLEAR, 0, 0);
        send_item(plst_pkg::CMD_READ, 0, 0);
        send_item(plst_pkg::CMD_REMOVE, 0, 0);
        send_item(plst_pkg::CMD_INSERT, 1, 32'sh1234_5678);
        // Build a list at head, tail and middle with extreme values.
        send_item(plst_pkg::CMD_INSERT, 0, 32'sh7FFF_FFFF);
        send_item(plst_pkg::CMD_INSERT, 0, 32'sh8000_0000);
        send_item(plst_pkg::CMD_INSERT, 2, -1);
        send_item(plst_pkg::CMD_INSERT, 1, 0);
        send_item(plst_pkg::CMD_INSERT, 127, 32'sh5555_5555);
        send_item(plst_pkg::CMD_READ, 0, 32'shAAAA_AAAA);
        send_item(plst_pkg::CMD_READ, 3, 0);
        send_item(plst_pkg::CMD_READ, 4, 0);
        send_item(plst_pkg::CMD_READ, 127, 0);
        send_item(plst_pkg::CMD_REMOVE, 3, 0);
        send_item(plst_pkg::CMD_REMOVE, 0, 0);
        send_item(plst_pkg::CMD_REMOVE, 127, 0);
        send_item(plst_pkg::CMD_READ, 1, 0);
        send_item(plst_pkg::CMD_CLEAR, 127, -1);
        send_item(plst_pkg::CMD_READ, 0, 0);
        send_item(plst_pkg::CMD_INSERT, 0, 32'sh5555_5555);
        send_item(plst_pkg::CMD_INSERT, 1, 32'shAAAA_AAAA);
        send_item(plst_pkg::CMD_REMOVE, 2, 0);
        send_item(plst_pkg::CMD_INSERT, 64, 0);
        send_item(plst_pkg::CMD_READ, 1, 0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                mode = MODE_FILL;
            else if (roll < 60)
                mode = MODE_DRAIN;
            else if (roll < 90)
                mode = MODE_MIXED;
            else
                mode = MODE_NOISE;
            seg_len = $urandom_range(20, 90);
            sender_bursting = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++)
            begin
                // Let the block drain completely once in the middle of the run.
                if (sent == PAUSE_AT_ITEM)
                begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (waiting_results != 0);
                end
                send_random(mode);
                sent++;
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (waiting_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && waiting_results == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls per item, bursts without stalls, and one
    // long hold-off that lets the block back up into its input.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_taken == HOLD_AT_RESULT)
                hold = HOLD_CYCLES;
            else if (receiver_bursting)
                hold = 0;
            else
                hold = $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            results_taken++;
            if (results_taken % 40 == 0)
                receiver_bursting = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
